>>> src/jsvi_pkg.sv
// Shared types and constants for the joint slew and velocity integrator.
`default_nettype none

package jsvi_pkg;

  localparam int NUM_JOINTS = 8;
  localparam int JOINT_W    = 3;
  localparam int CNT_W      = 4;
  localparam int POS_W      = 32;
  localparam int STEP_W     = 31;
  localparam int TIMEOUT_W  = 16;
  localparam int ELAPSED_W  = 16;
  localparam int TIME_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [TIME_W-1:0]    TIME_MAX         = '1;
  localparam logic [STEP_W-1:0]    MAX_STEP_RST     = STEP_W'(66);
  localparam logic [TIMEOUT_W-1:0] VEL_TIMEOUT_RST  = TIMEOUT_W'(32768);
  localparam logic [CNT_W-1:0]     ACTIVE_RST       = CNT_W'(NUM_JOINTS);

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SET_GOAL = 2'd1,
    OP_SET_POS  = 2'd2,
    OP_SET_VEL  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_STEP    = 2'd0,
    CFG_VEL_TIMEOUT = 2'd1,
    CFG_ACTIVE      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    op_t                         op;
    logic                        known;
    logic [JOINT_W-1:0]          joint;
    logic signed [POS_W-1:0]     value;
    logic [ELAPSED_W-1:0]        elapsed;
  } cmd_t;

  typedef struct packed {
    logic [STEP_W-1:0]    max_step;
    logic [TIMEOUT_W-1:0] vel_timeout;
    logic [CNT_W-1:0]     cnt;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/joint_slew_and_velocity_integrator_core.sv
// Top level of the multi-joint slew and velocity integrator.
//
// Input channel (in_valid / in_stall): one transaction carries an operation,
// a joint, a Q16.16 value and an elapsed time. Set goal, set position and
// goal, and set velocity produce no output. A tick moves every active joint
// (slew-limited toward its goal in position mode, or by elapsed * velocity
// while the velocity window is open in velocity mode) and then reports each
// active joint's position on the output channel, in index order, with last
// marking the final one.
// An input transaction passes a front register and a four-entry command
// queue before the execution stage takes it; a set command is applied as it
// is popped. A tick steps through the active joints in turn, forming each
// step in the calc state (including the 17 x 32 multiply), then adding,
// saturating and writing it back in the apply state, which also loads the
// output register. When the receiver stalls, the output register holds its
// transaction and the sequencer waits; the queue keeps absorbing input until
// it fills, and then in_stall rises. Reset (rst, synchronous) zeroes all
// joint state, selects position mode, saturates the timeout count and
// restores the registers to max_step 66, velocity_timeout 32768, active_joints
// 8. Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module joint_slew_and_velocity_integrator_core import jsvi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              operation,
  input  logic [JOINT_W-1:0]      joint,
  input  logic signed [POS_W-1:0] value,
  input  logic [ELAPSED_W-1:0]    elapsed,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [JOINT_W-1:0]      joint_index,
  output logic signed [POS_W-1:0] position,
  output logic                    last
);

  logic [STEP_W-1:0]    max_step;
  logic [TIMEOUT_W-1:0] velocity_timeout;
  logic [CNT_W-1:0]     active_joints;
  cfg_t                 cfg;

  logic f_valid;
  cmd_t f_cmd;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_step         <= MAX_STEP_RST;
      velocity_timeout <= VEL_TIMEOUT_RST;
      active_joints    <= ACTIVE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_STEP:    max_step         <= cfg_data;
        CFG_VEL_TIMEOUT: velocity_timeout <= cfg_data[TIMEOUT_W-1:0];
        CFG_ACTIVE:      active_joints    <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the active count to 1..NUM_JOINTS.
  always_comb begin
    cfg.max_step    = max_step;
    cfg.vel_timeout = velocity_timeout;
    if (active_joints == '0) begin
      cfg.cnt = CNT_W'(1);
    end else if (active_joints > CNT_W'(NUM_JOINTS)) begin
      cfg.cnt = CNT_W'(NUM_JOINTS);
    end else begin
      cfg.cnt = active_joints;
    end
  end

  jsvi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cnt       (cfg.cnt),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .joint     (joint),
    .value     (value),
    .elapsed   (elapsed),
    .f_valid   (f_valid),
    .f_cmd     (f_cmd),
    .q_full    (q_full)
  );

  jsvi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_valid),
    .push_cmd   (f_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  jsvi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .joint_index (joint_index),
    .position    (position),
    .last        (last)
  );

`ifndef SYNTH
  // The final report of a tick is always the highest active joint.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (CNT_W'(joint_index) + 1'b1) == cfg.cnt)
    else $error("last marker not on highest active joint");

  // Reports that are not last stay below the highest active joint.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> (CNT_W'(joint_index) + 1'b1) < cfg.cnt)
    else $error("non-final report outside active joints");

  // The queue only pops when it holds a command.
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid)
    else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire

>>> src/jsvi_front.sv
// Input stage: register and classify incoming transactions.
`default_nettype none

module jsvi_front import jsvi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [CNT_W-1:0]        cnt,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              operation,
  input  logic [JOINT_W-1:0]      joint,
  input  logic signed [POS_W-1:0] value,
  input  logic [ELAPSED_W-1:0]    elapsed,
  output logic                    f_valid,
  output cmd_t                    f_cmd,
  input  logic                    q_full
);

  logic accept;

  assign in_stall = f_valid && q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (!q_full) begin
      f_valid <= 1'b0;
    end
  end

  // Resolve whether the addressed joint is in use now, so the back end only applies it.
  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd.op      <= op_t'(operation);
      f_cmd.known   <= {1'b0, joint} < cnt;
      f_cmd.joint   <= joint;
      f_cmd.value   <= value;
      f_cmd.elapsed <= elapsed;
    end
  end

endmodule

`default_nettype wire

>>> src/jsvi_queue.sv
// Short command queue between the front and back stages.
`default_nettype none

module jsvi_queue import jsvi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               wr;
  logic               rd;

  assign full       = count == Q_CNT_W'(Q_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign wr         = push && !full;
  assign rd         = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) entries[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

>>> src/jsvi_back.sv
// Execution stage: joint state, set commands and the per-joint tick sequencer.
`default_nettype none

module jsvi_back import jsvi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    head_valid,
  input  cmd_t                    head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [JOINT_W-1:0]      joint_index,
  output logic signed [POS_W-1:0] position,
  output logic                    last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CALC  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t                  st;
  logic [JOINT_W-1:0]      idx;
  logic [ELAPSED_W-1:0]    el;
  logic                    mv_vel;
  logic                    mv_pos;
  logic                    vmode;
  logic [TIME_W-1:0]       tsvc;
  logic signed [POS_W:0]   delta;

  logic signed [POS_W-1:0] positions  [NUM_JOINTS];
  logic signed [POS_W-1:0] goals      [NUM_JOINTS];
  logic signed [POS_W-1:0] velocities [NUM_JOINTS];

  logic [TIME_W:0]         tsum;
  logic [TIME_W-1:0]       tsat;
  logic signed [POS_W-1:0] pos_cur;
  logic signed [POS_W-1:0] goal_cur;
  logic signed [POS_W+ELAPSED_W:0] prod;
  logic signed [POS_W:0]   vel_delta;
  logic signed [POS_W:0]   diff;
  logic signed [POS_W:0]   lim;
  logic signed [POS_W:0]   jump;
  logic signed [POS_W+1:0] sum;
  logic signed [POS_W-1:0] sat;
  logic                    last_j;
  logic                    out_free;
  logic                    apply;

  assign pop      = (st == ST_IDLE) && head_valid;
  assign pos_cur  = positions[idx];
  assign goal_cur = goals[idx];

  // Timeout count advances by elapsed and saturates.
  assign tsum = {1'b0, tsvc} + (TIME_W + 1)'(head.elapsed);
  assign tsat = tsum[TIME_W] ? TIME_MAX : tsum[TIME_W-1:0];

  // Velocity step: floor(elapsed * v / 2^16).
  assign prod      = $signed({1'b0, el}) * velocities[idx];
  assign vel_delta = prod[POS_W+ELAPSED_W:ELAPSED_W];

  // Slew step: goal minus position, clamped to +/- max_step.
  assign diff = {goal_cur[POS_W-1], goal_cur} - {pos_cur[POS_W-1], pos_cur};
  assign lim  = $signed({2'b00, cfg.max_step});
  always_comb begin
    if (diff > lim) begin
      jump = lim;
    end else if (diff < -lim) begin
      jump = -lim;
    end else begin
      jump = diff;
    end
  end

  assign sum = {{2{pos_cur[POS_W-1]}}, pos_cur} + {delta[POS_W], delta};
  always_comb begin
    if (sum[POS_W+1:POS_W-1] == 3'b000 || sum[POS_W+1:POS_W-1] == 3'b111) begin
      sat = sum[POS_W-1:0];
    end else if (sum[POS_W+1]) begin
      sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  assign last_j   = (CNT_W'(idx) + 1'b1) == cfg.cnt;
  assign out_free = !out_valid || !out_stall;
  assign apply    = (st == ST_APPLY) && out_free;

  // Sequencer and mode state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      vmode     <= 1'b0;
      tsvc      <= TIME_MAX;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (apply) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (pop) begin
            case (head.op)
              OP_TICK: begin
                tsvc <= tsat;
                idx  <= '0;
                st   <= ST_CALC;
              end
              OP_SET_GOAL, OP_SET_POS: begin
                vmode <= 1'b0;
              end
              OP_SET_VEL: begin
                vmode <= 1'b1;
                tsvc  <= '0;
              end
              default: begin
                vmode <= vmode;
              end
            endcase
          end
        end
        ST_CALC: begin
          st <= ST_APPLY;
        end
        ST_APPLY: begin
          if (out_free) begin
            if (last_j) begin
              st <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
              st  <= ST_CALC;
            end
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // Latch the tick's motion decision and elapsed time, then the step and the report.
  always_ff @(posedge clk) begin
    if (pop && head.op == OP_TICK) begin
      el     <= head.elapsed;
      mv_vel <= vmode && (tsat < {1'b0, cfg.vel_timeout});
      mv_pos <= !vmode;
    end
    if (st == ST_CALC) begin
      if (mv_vel) begin
        delta <= vel_delta;
      end else if (mv_pos) begin
        delta <= jump;
      end else begin
        delta <= '0;
      end
    end
    if (apply) begin
      joint_index <= idx;
      position    <= sat;
      last        <= last_j;
    end
  end

  // Joint state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_JOINTS; i++) begin
        positions[i]  <= '0;
        goals[i]      <= '0;
        velocities[i] <= '0;
      end
    end else begin
      if (pop && head.known) begin
        case (head.op)
          OP_SET_GOAL: begin
            goals[head.joint] <= head.value;
          end
          OP_SET_POS: begin
            goals[head.joint]     <= head.value;
            positions[head.joint] <= head.value;
          end
          OP_SET_VEL: begin
            velocities[head.joint] <= head.value;
          end
          default: begin
          end
        endcase
      end
      if (apply) positions[idx] <= sat;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the joint slew and velocity integrator core.
`timescale 1ns / 100ps

module tb_top;
  import jsvi_pkg::*;

  // Cycles with no transaction on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 4000;
  // Let queued set commands retire after the last report has come out.
  localparam int DRAIN_CYCLES   = 40;
  localparam int SEGMENT_ITEMS  = 17;
  localparam int SEGMENTS       = 6;
  localparam int REPORT_LIMIT   = 10;

  // One joint report as it leaves the block.
  typedef struct {
    logic [JOINT_W-1:0]      joint_index;
    logic signed [POS_W-1:0] position;
    logic                    last;
  } report_t;

  // One row of the directed table. Where typed is set, the report of joint tj
  // on this tick is checked against tpos rather than against the predictor.
  typedef struct {
    op_t                     op;
    logic [JOINT_W-1:0]      jt;
    logic signed [POS_W-1:0] val;
    logic [ELAPSED_W-1:0]    el;
    bit                      typed;
    logic [JOINT_W-1:0]      tj;
    logic signed [POS_W-1:0] tpos;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              operation = '0;
  logic [JOINT_W-1:0]      joint = '0;
  logic signed [POS_W-1:0] value = '0;
  logic [ELAPSED_W-1:0]    elapsed = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [JOINT_W-1:0]      joint_index;
  logic signed [POS_W-1:0] position;
  logic                    last;

  // Shadow copy of the joint state and the registers.
  logic signed [POS_W-1:0] pos_m  [NUM_JOINTS];
  logic signed [POS_W-1:0] goal_m [NUM_JOINTS];
  logic signed [POS_W-1:0] vel_m  [NUM_JOINTS];
  logic                    vel_mode_m;
  logic [TIME_W-1:0]       since_vel_m;
  logic [STEP_W-1:0]       step_m;
  logic [TIMEOUT_W-1:0]    timeout_m;
  logic [CNT_W-1:0]        active_m;

  report_t   pending_reports[$];
  plan_row_t command_plan[$];

  int send_idle = 0;
  int recv_idle = 0;
  int items_sent = 0;
  int ticks_sent = 0;
  int reports_checked = 0;
  int settings_applied = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  joint_slew_and_velocity_integrator_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .joint       (joint),
    .value       (value),
    .elapsed     (elapsed),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .joint_index (joint_index),
    .position    (position),
    .last        (last)
  );

  always #6 clk = ~clk;

  // Effective joint count: zero behaves as one, anything above the joint
  // count is clipped to it.
  function automatic int live_joints();
    if (active_m == 0) return 1;
    if (active_m > NUM_JOINTS) return NUM_JOINTS;
    return int'(active_m);
  endfunction

  function automatic logic signed [POS_W-1:0] saturate_q(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return POS_W'(x);
  endfunction

  // Advance the shadow state by one accepted command and queue the joint
  // reports that a tick produces.
  task automatic track_command(input op_t op, input logic [JOINT_W-1:0] jt,
                               input logic signed [POS_W-1:0] val,
                               input logic [ELAPSED_W-1:0] el);
    int      n;
    longint  ev;
    longint  since_sum;
    longint  delta;
    longint  lim;
    longint  jump;
    report_t r;
    n  = live_joints();
    ev = el;
    case (op)
      OP_SET_GOAL: begin
        if (jt < n) goal_m[jt] = val;
        vel_mode_m = 1'b0;
      end
      OP_SET_POS: begin
        if (jt < n) begin
          goal_m[jt] = val;
          pos_m[jt]  = val;
        end
        vel_mode_m = 1'b0;
      end
      OP_SET_VEL: begin
        // Unknown joints still switch the mode and restart the window.
        if (jt < n) vel_m[jt] = val;
        vel_mode_m  = 1'b1;
        since_vel_m = '0;
      end
      default: begin
        // Advance the time count first, saturating, then test the window.
        since_sum = since_vel_m;
        since_sum = since_sum + ev;
        since_vel_m = (since_sum > TIME_MAX) ? TIME_MAX : TIME_W'(since_sum);
        lim = step_m;
        for (int i = 0; i < n; i++) begin
          if (vel_mode_m) begin
            if (since_vel_m < timeout_m) begin
              // Arithmetic shift floors towards minus infinity.
              delta    = (ev * longint'(vel_m[i])) >>> 16;
              pos_m[i] = saturate_q(longint'(pos_m[i]) + delta);
            end
          end else begin
            jump = longint'(goal_m[i]) - longint'(pos_m[i]);
            if (jump > lim) jump = lim;
            if (jump < -lim) jump = -lim;
            pos_m[i] = saturate_q(longint'(pos_m[i]) + jump);
          end
          r.joint_index = JOINT_W'(i);
          r.position    = pos_m[i];
          r.last        = (i == n - 1);
          pending_reports = {pending_reports, r};
        end
        ticks_sent++;
      end
    endcase
  endtask

  // Present one command from the falling edge, hold it until the rising edge
  // that takes it, then update the shadow state. Random gaps go before it;
  // the payload wanders while valid is low.
  task automatic send_item(input op_t op, input logic [JOINT_W-1:0] jt,
                           input logic signed [POS_W-1:0] val,
                           input logic [ELAPSED_W-1:0] el);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid  <= 1'b0;
      operation <= 2'($urandom);
      value     <= $urandom;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    joint     <= jt;
    value     <= val;
    elapsed   <= el;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    track_command(op, jt, val, el);
  endtask

  // Drop valid, wait for every expected report, then let the queue empty.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers, one per falling edge, with the block idle.
  task automatic apply_setting(input logic [STEP_W-1:0] stp,
                               input logic [TIMEOUT_W-1:0] tmo,
                               input logic [CNT_W-1:0] cnt);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_STEP;
    cfg_data  <= CFG_DATA_W'(stp);
    @(negedge clk);
    cfg_index <= CFG_VEL_TIMEOUT;
    cfg_data  <= CFG_DATA_W'(tmo);
    @(negedge clk);
    cfg_index <= CFG_ACTIVE;
    cfg_data  <= CFG_DATA_W'(cnt);
    @(negedge clk);
    cfg_we    <= 1'b0;
    step_m    = stp;
    timeout_m = tmo;
    active_m  = cnt;
    settings_applied++;
  endtask

  // Mostly a joint in use; now and then any index, so unknown joints appear
  // whenever fewer than all joints are active.
  function automatic logic [JOINT_W-1:0] pick_joint();
    if ($urandom_range(4) == 0) return JOINT_W'($urandom);
    return JOINT_W'($urandom_range(live_joints() - 1));
  endfunction

  function automatic logic signed [POS_W-1:0] pick_q();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed(POS_W'($urandom_range(32'h8_0000))) - 32'sh4_0000;
      2: case ($urandom_range(3))
           0: return 32'sh7FFF_FFFF;
           1: return 32'sh8000_0000;
           2: return 32'sh0;
           default: return -32'sd1;
         endcase
      default: return $signed(POS_W'($urandom_range(32'h200_0000))) - 32'sh100_0000;
    endcase
  endfunction

  // Short steps keep velocity mode inside its window; some full-range ones
  // push the time count to saturation.
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    if ($urandom_range(4) == 0) return ELAPSED_W'($urandom);
    return ELAPSED_W'($urandom_range(2000));
  endfunction

  task automatic plan_row(input op_t op, input logic [JOINT_W-1:0] jt,
                          input logic signed [POS_W-1:0] val,
                          input logic [ELAPSED_W-1:0] el, input bit typed,
                          input logic [JOINT_W-1:0] tj,
                          input logic signed [POS_W-1:0] tpos);
    plan_row_t r;
    r = '{op, jt, val, el, typed, tj, tpos};
    command_plan = {command_plan, r};
  endtask

  // Random traffic: mostly well-formed set-then-tick sequences with random
  // content, plus broken mode switches and pure noise.
  task automatic run_segment(input int quota);
    int first;
    int kind;
    first = items_sent;
    while (items_sent - first < quota) begin
      kind = $urandom_range(9);
      if (kind <= 3) begin
        repeat ($urandom_range(1, 3))
          send_item(OP_SET_VEL, pick_joint(), pick_q(), ELAPSED_W'($urandom));
        repeat ($urandom_range(1, 3))
          send_item(OP_TICK, JOINT_W'($urandom), $urandom, pick_elapsed());
      end else if (kind <= 6) begin
        repeat ($urandom_range(1, 3))
          send_item($urandom_range(1) ? OP_SET_GOAL : OP_SET_POS, pick_joint(),
                    pick_q(), ELAPSED_W'($urandom));
        repeat ($urandom_range(1, 2))
          send_item(OP_TICK, JOINT_W'($urandom), $urandom, pick_elapsed());
      end else if (kind == 7) begin
        // Velocity command cut short by a goal write before the tick.
        send_item(OP_SET_VEL, pick_joint(), pick_q(), pick_elapsed());
        send_item(OP_SET_GOAL, pick_joint(), pick_q(), pick_elapsed());
        send_item(OP_TICK, JOINT_W'($urandom), $urandom, pick_elapsed());
      end else begin
        send_item(op_t'($urandom_range(3)), JOINT_W'($urandom), $urandom,
                  ELAPSED_W'($urandom));
      end
    end
  endtask

  // Receiver side: stall at random from the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Compare each report taken at a rising edge with the oldest expectation.
  always @(posedge clk) begin : check_reports
    report_t want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected report: joint %0d position %h last %b",
                   $realtime, joint_index, position, last);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (joint_index !== want.joint_index || position !== want.position ||
            last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"[%0t] report mismatch: expected joint %0d position %h last %b,",
                      " got joint %0d position %h last %b"},
                     $realtime, want.joint_index, want.position, want.last,
                     joint_index, position, last);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((in_valid && in_stall == 1'b0) || (out_valid === 1'b1 && out_stall == 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d idle cycles, %0d reports outstanding",
                 quiet_cycles, pending_reports.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    plan_row_t row;
    int        n;
    // Directed table, all at the reset register values (step 66,
    // window 32768, eight joints).
    // Straight after reset: position mode, everything at zero.
    plan_row(OP_TICK,     0, 32'sh0,         16'h0000, 1, 0, 32'sh0);
    // Slew towards the largest goal, capped at the maximum step.
    plan_row(OP_SET_GOAL, 0, 32'sh7FFF_FFFF, 16'h0000, 0, 0, 32'sh0);
    plan_row(OP_TICK,     0, 32'sh0,         16'hFFFF, 1, 0, 32'sh0000_0042);
    // Most negative position chasing the largest goal.
    plan_row(OP_SET_POS,  1, 32'sh8000_0000, 16'h0000, 0, 0, 32'sh0);
    plan_row(OP_SET_GOAL, 1, 32'sh7FFF_FFFF, 16'h0000, 0, 0, 32'sh0);
    plan_row(OP_TICK,     7, 32'sh0,         16'h0000, 1, 1, 32'sh8000_0042);
    // Positions near both rails, then extreme and unit velocities.
    plan_row(OP_SET_POS,  2, 32'sh7FFF_0000, 16'h0000, 0, 0, 32'sh0);
    plan_row(OP_SET_POS,  3, 32'sh8001_0000, 16'h0000, 0, 0, 32'sh0);
    plan_row(OP_SET_VEL,  2, 32'sh7FFF_FFFF, 16'h0000, 0, 0, 32'sh0);
    plan_row(OP_SET_VEL,  3, 32'sh8000_0000, 16'h0000, 0, 0, 32'sh0);
    plan_row(OP_SET_VEL,  4, -32'sd1,        16'h0000, 0, 0, 32'sh0);
    plan_row(OP_SET_VEL,  5, 32'sh0001_0000, 16'h0000, 0, 0, 32'sh0);
    // A tiny negative product floors to minus one.
    plan_row(OP_TICK,     0, 32'sh0,         16'h0001, 1, 4, -32'sd1);
    // Window expired: nothing moves but everything is still reported.
    plan_row(OP_TICK,     0, 32'sh0,         16'hFFFF, 1, 5, 32'sh0000_0001);
    // Reopen the window and run into both saturation rails.
    plan_row(OP_SET_VEL,  2, 32'sh7FFF_FFFF, 16'h0000, 0, 0, 32'sh0);
    plan_row(OP_TICK,     0, 32'sh0,         16'h7FFF, 1, 2, 32'sh7FFF_FFFF);
    // Time count lands exactly on the window: closed.
    plan_row(OP_TICK,     0, 32'sh0,         16'h0001, 1, 3, 32'sh8000_0000);
    plan_row(OP_TICK,     0, 32'sh0,         16'h0000, 0, 0, 32'sh0);
    // Back to position mode; elapsed is then ignored.
    plan_row(OP_SET_GOAL, 6, 32'sh0000_0100, 16'h1234, 0, 0, 32'sh0);
    plan_row(OP_TICK,     0, 32'sh0,         16'h8000, 0, 0, 32'sh0);
    // A gap smaller than the step closes in one tick.
    plan_row(OP_SET_POS,  7, -32'sd5,        16'h0000, 0, 0, 32'sh0);
    plan_row(OP_SET_GOAL, 7, 32'sd5,         16'h0000, 0, 0, 32'sh0);
    plan_row(OP_TICK,     0, 32'sh0,         16'h0000, 1, 7, 32'sd5);

    // Initialise the shadow state to its reset values.
    for (int i = 0; i < NUM_JOINTS; i++) begin
      pos_m[i]  = '0;
      goal_m[i] = '0;
      vel_m[i]  = '0;
    end
    vel_mode_m  = 1'b0;
    since_vel_m = TIME_MAX;
    step_m      = MAX_STEP_RST;
    timeout_m   = VEL_TIMEOUT_RST;
    active_m    = ACTIVE_RST;

    // Hold reset, then release it on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle = 33;
    recv_idle = 46;
    foreach (command_plan[k]) begin
      row = command_plan[k];
      send_item(row.op, row.jt, row.val, row.el);
      // Swap in the hand-worked position for the selected joint.
      n = live_joints();
      if (row.op == OP_TICK && row.typed && row.tj < n)
        pending_reports[pending_reports.size() - n + row.tj].position = row.tpos;
    end

    // Random segments, each under its own register setting; the idling
    // scheme changes every two segments.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin send_idle = 33; recv_idle = 46; end
        1: begin send_idle = 46; recv_idle = 33; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (seg)
        0: apply_setting('0, '1, CNT_W'(NUM_JOINTS));
        1: apply_setting('1, '0, '1);
        2: apply_setting(STEP_W'($urandom), TIMEOUT_W'($urandom), '0);
        3: apply_setting(STEP_W'(32'h1_0000), TIMEOUT_W'(1000), CNT_W'(3));
        4: apply_setting(STEP_W'($urandom_range(32'h4_0000)), TIMEOUT_W'($urandom),
                         CNT_W'($urandom_range(1, NUM_JOINTS)));
        default: apply_setting(MAX_STEP_RST, VEL_TIMEOUT_RST, CNT_W'(5));
      endcase
      run_segment(SEGMENT_ITEMS);
    end

    settle();
    $display({"Sent %0d commands (%0d ticks) across %0d register settings",
              " and three idling schemes."},
             items_sent, ticks_sent, settings_applied + 1);
    $display("Checked %0d joint reports, %0d mismatches.", reports_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> joint_slew_and_velocity_integrator_core.f
src/jsvi_pkg.sv
src/jsvi_front.sv
src/jsvi_queue.sv
src/jsvi_back.sv
src/joint_slew_and_velocity_integrator_core.sv
tb/sv/tb_top.sv
